/* rtl/core/hashed_timing_wheel_macros.svh */
// assertion macros for the hashed timing wheel
`ifndef HASHED_TIMING_WHEEL_MACROS_SVH
`define HASHED_TIMING_WHEEL_MACROS_SVH

`ifndef SYNTH
// antecedent and consequent in the same cycle
`define HTW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent in the cycle after the antecedent
`define HTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/htw_pkg.sv */
// types, codes and constants of the hashed timing wheel
`timescale 1ns / 1ps
package htw_pkg;

    localparam int DEF_WHEEL_SIZE = 8;
    localparam int DEF_MAX_TASKS  = 32;
    localparam int DEF_TICK_WIDTH = 32;

    localparam int TASK_W     = 5;
    localparam int DELAY_W    = 32;
    localparam int KIND_W     = 3;
    localparam int OUT_TICK_W = 32;
    localparam int RESULT_CAP = 32;
    localparam int S_TUSER_W  = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [1:0] {
        REQ_INSERT,
        REQ_REMOVE,
        REQ_TICK,
        REQ_SET_KIND
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_IGNORED,
        STAT_BUSY,
        STAT_FATAL
    } t_status;

    localparam logic [KIND_W-1:0] KIND_SLEEP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PEND       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEND_SUSP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SLEEP_SUSP = 3'd3;

    typedef struct packed {
        t_status             status;
        logic                expired;
        logic [TASK_W-1:0]   task_id;
        logic                new_state;
        logic                block_result;
        logic                leave_block_list;
        logic                reset_mutex_priority;
        logic                add_to_ready;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD,
        S_INS_WALK,
        S_INS_NODE,
        S_LINK_A,
        S_LINK_B,
        S_UNLINK,
        S_TICK_WALK,
        S_TICK_NODE,
        S_FINISH
    } t_state;

    function automatic t_result plain_result(t_status st, logic [TASK_W-1:0] id);
        t_result r;
        r = '0;
        r.status  = st;
        r.task_id = id;
        return r;
    endfunction

    // result of a due task, by its wait kind
    function automatic t_result expire_result(logic [KIND_W-1:0] kind,
                                              logic [TASK_W-1:0] id);
        t_result r;
        r = '0;
        r.status  = STAT_OK;
        r.expired = 1'b1;
        r.task_id = id;
        case (kind)
            KIND_SLEEP: begin
                r.add_to_ready = 1'b1;
            end
            KIND_PEND: begin
                r.block_result         = 1'b1;
                r.leave_block_list     = 1'b1;
                r.reset_mutex_priority = 1'b1;
                r.add_to_ready         = 1'b1;
            end
            KIND_PEND_SUSP: begin
                r.new_state            = 1'b1;
                r.block_result         = 1'b1;
                r.leave_block_list     = 1'b1;
                r.reset_mutex_priority = 1'b1;
            end
            KIND_SLEEP_SUSP: begin
                r.new_state = 1'b1;
            end
            default: begin
                r.status = STAT_FATAL;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/hashed_timing_wheel.sv */
// Hashed timing wheel: task timeouts kept in sorted linked buckets.
// Every request runs as a sequence of states and the input is not ready
// meanwhile; an output stall holds the sequence until the result is taken.
// Set-kind and an ignored request go straight to the finish state. A remove
// reads the task's links and unlinks it before it finishes. A tick reads the
// bucket head, then reads and decides on each task looked at in its bucket
// until the scan reaches the end of the bucket, a task not yet due or the
// result cap. An insert first reduces the expiry tick modulo WHEEL_SIZE one
// byte per cycle through constant remainder tables. It then reads the bucket
// head and walks the sorted bucket until it reaches its end or an entry with
// more time left, and then links the task in.
// The link, expiry and kind stores each have one write port and one read
// port with a registered read, so each list step is a read state followed
// by a decide state. Results leave through an output register. A tick sends
// one result per due task (at most 32), or one empty result when nothing is
// due, with tlast on the final one.
`timescale 1ns / 1ps
`include "hashed_timing_wheel_macros.svh"
module hashed_timing_wheel #(
    parameter int WHEEL_SIZE = htw_pkg::DEF_WHEEL_SIZE,
    parameter int MAX_TASKS  = htw_pkg::DEF_MAX_TASKS,
    parameter int TICK_WIDTH = htw_pkg::DEF_TICK_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // task_id[4:0], delay[36:5], wait_kind[39:37]
    input  logic [htw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [htw_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // status[1:0], expired[2], out_task[7:3], new_state[8], block_result[9],
    // leave_block_list[10], reset_mutex_priority[11], add_to_ready[12],
    // current_tick[44:13], zero[47:45]
    output logic [htw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tlast
);
    import htw_pkg::*;

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LINK_W = $clog2(MAX_TASKS + 1);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int BKT_W  = $clog2(WHEEL_SIZE);
    localparam int NBYTES = (TICK_WIDTH + 7) / 8;
    localparam int EXT_W  = NBYTES * 8;
    localparam int MODC_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int CMP_W  = (TICK_WIDTH > DELAY_W) ? TICK_WIDTH : DELAY_W;
    localparam int LIMIT  = (MAX_TASKS < RESULT_CAP) ? MAX_TASKS : RESULT_CAP;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_TASKS);

    // remainder of each byte value
    function automatic logic [256*BKT_W-1:0] byte_mod_tbl();
        logic [256*BKT_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[i*BKT_W +: BKT_W] = BKT_W'(i % WHEEL_SIZE);
        end
        return tbl;
    endfunction

    // remainder of a partial remainder shifted up by one byte
    function automatic logic [256*BKT_W-1:0] shift_mod_tbl();
        logic [256*BKT_W-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[i*BKT_W +: BKT_W] = BKT_W'((i * 256) % WHEEL_SIZE);
        end
        return tbl;
    endfunction

    localparam logic [256*BKT_W-1:0] BYTE_MOD  = byte_mod_tbl();
    localparam logic [256*BKT_W-1:0] SHIFT_MOD = shift_mod_tbl();

    // stores
    logic [TICK_WIDTH-1:0] m_exp  [MAX_TASKS];
    logic [LINK_W-1:0]     m_next [MAX_TASKS];
    logic [LINK_W-1:0]     m_prev [MAX_TASKS];
    logic [KIND_W-1:0]     m_kind [MAX_TASKS];
    logic [BKT_W-1:0]      m_bkt  [MAX_TASKS];
    logic [LINK_W-1:0]     m_head [WHEEL_SIZE];
    logic                  r_head_vld [WHEEL_SIZE];
    logic                  r_in_wheel [MAX_TASKS];

    logic [TICK_WIDTH-1:0] r_rd_exp;
    logic [LINK_W-1:0]     r_rd_next, r_rd_prev, r_rd_head;
    logic [KIND_W-1:0]     r_rd_kind;
    logic [BKT_W-1:0]      r_rd_bkt;

    // sequencer registers
    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [BKT_W-1:0]      r_tick_bkt, n_tick_bkt;
    logic [TICK_WIDTH-1:0] r_exp, n_exp;
    logic [DELAY_W-1:0]    r_delay, n_delay;
    logic [TASK_W-1:0]     r_task, n_task;
    logic [BKT_W-1:0]      r_bkt, n_bkt;
    logic [MODC_W-1:0]     r_modc, n_modc;
    logic [LINK_W-1:0]     r_q, n_q;
    logic [LINK_W-1:0]     r_before, n_before;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pend_vld, n_pend_vld;
    t_result               r_pend, n_pend;
    logic                  r_out_vld;
    t_result               r_out;
    logic                  r_out_last;
    logic [TICK_WIDTH-1:0] r_out_tick;

    // write and read ports
    logic                  exp_we, next_we, prev_we, kind_we, bkt_we, head_we;
    logic [IDX_W-1:0]      exp_wa, next_wa, prev_wa, kind_wa, bkt_wa;
    logic [BKT_W-1:0]      head_wa;
    logic [TICK_WIDTH-1:0] exp_wd;
    logic [LINK_W-1:0]     next_wd, prev_wd, head_wd;
    logic [BKT_W-1:0]      bkt_wd;
    logic                  inw_set, inw_clr;
    logic [IDX_W-1:0]      inw_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic [BKT_W-1:0]      hd_addr;
    logic                  unl;

    logic                  push, push_last;
    t_result               push_res;

    logic                  s_fire, out_free, task_ok;
    t_req                  req_in;
    logic [TASK_W-1:0]     in_task;
    logic [DELAY_W-1:0]    in_delay;
    logic [KIND_W-1:0]     in_kind;
    logic [IDX_W-1:0]      in_idx;
    logic [EXT_W-1:0]      exp_ext;
    logic [7:0]            mod_byte;
    logic [BKT_W:0]        mod_t;
    logic [TICK_WIDTH-1:0] rem;

    assign req_in   = t_req'(i_s_tuser);
    assign in_task  = i_s_tdata[4:0];
    assign in_delay = i_s_tdata[36:5];
    assign in_kind  = i_s_tdata[39:37];
    assign in_idx   = IDX_W'(in_task);
    assign task_ok  = (32'(in_task) < 32'(MAX_TASKS));
    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_vld || i_m_tready;
    assign exp_ext  = EXT_W'(r_exp);
    assign mod_byte = exp_ext[{r_modc, 3'b000} +: 8];
    // partial remainder shifted by a byte plus the next byte, both reduced
    assign mod_t    = {1'b0, SHIFT_MOD[int'(r_bkt) * BKT_W +: BKT_W]}
                    + {1'b0, BYTE_MOD[int'(mod_byte) * BKT_W +: BKT_W]};
    assign rem      = r_rd_exp - r_tick;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_tick     = r_tick;
        n_tick_bkt = r_tick_bkt;
        n_exp      = r_exp;
        n_delay    = r_delay;
        n_task     = r_task;
        n_bkt      = r_bkt;
        n_modc     = r_modc;
        n_q        = r_q;
        n_before   = r_before;
        n_cnt      = r_cnt;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        exp_we  = 1'b0; exp_wa  = '0; exp_wd  = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        kind_we = 1'b0; kind_wa = '0;
        bkt_we  = 1'b0; bkt_wa  = '0; bkt_wd  = '0;
        head_we = 1'b0; head_wa = '0; head_wd = '0;
        inw_set = 1'b0; inw_clr = 1'b0; inw_idx = '0;
        rd_addr = '0;
        hd_addr = r_bkt;
        unl     = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        push_res  = r_pend;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_req      = req_in;
                    n_task     = in_task;
                    n_pend_vld = 1'b1;
                    n_pend     = plain_result(STAT_OK, in_task);
                    n_state    = S_FINISH;
                    if (req_in == REQ_TICK) begin
                        n_tick     = r_tick + 1'b1;
                        n_pend_vld = 1'b0;
                        n_cnt      = '0;
                        // counter wrap lands on bucket zero
                        if (&r_tick || r_tick_bkt == BKT_W'(WHEEL_SIZE - 1)) begin
                            n_tick_bkt = '0;
                        end else begin
                            n_tick_bkt = r_tick_bkt + 1'b1;
                        end
                        n_bkt   = n_tick_bkt;
                        n_state = S_HEAD_RD;
                    end else if (!task_ok) begin
                        n_pend.status = STAT_IGNORED;
                    end else begin
                        case (req_in)
                            REQ_INSERT: begin
                                if (in_delay == '0) begin
                                    n_pend.status = STAT_IGNORED;
                                end else if (r_in_wheel[in_idx]) begin
                                    n_pend.status = STAT_BUSY;
                                end else begin
                                    n_exp   = r_tick + TICK_WIDTH'(in_delay);
                                    n_delay = in_delay;
                                    n_bkt   = '0;
                                    n_modc  = MODC_W'(NBYTES - 1);
                                    n_state = S_MOD;
                                end
                            end
                            REQ_REMOVE: begin
                                if (r_in_wheel[in_idx]) begin
                                    rd_addr = in_idx;
                                    n_state = S_UNLINK;
                                end else begin
                                    n_pend.status = STAT_IGNORED;
                                end
                            end
                            default: begin
                                kind_we = 1'b1;
                                kind_wa = in_idx;
                            end
                        endcase
                    end
                end
            end
            S_MOD: begin
                // one byte per cycle, most significant first
                if (mod_t >= (BKT_W + 1)'(WHEEL_SIZE)) begin
                    n_bkt = BKT_W'(mod_t - (BKT_W + 1)'(WHEEL_SIZE));
                end else begin
                    n_bkt = BKT_W'(mod_t);
                end
                if (r_modc == '0) begin
                    n_state = S_HEAD_RD;
                end else begin
                    n_modc = r_modc - 1'b1;
                end
            end
            S_HEAD_RD: begin
                hd_addr  = r_bkt;
                n_cnt    = '0;
                n_before = NIL;
                n_state  = S_HEAD;
            end
            S_HEAD: begin
                n_q     = r_rd_head;
                n_state = (r_req == REQ_TICK) ? S_TICK_WALK : S_INS_WALK;
            end
            S_INS_WALK: begin
                if (r_q >= NIL || r_cnt == CNT_W'(MAX_TASKS)) begin
                    n_state = S_LINK_A;
                end else begin
                    rd_addr = r_q[IDX_W-1:0];
                    n_state = S_INS_NODE;
                end
            end
            S_INS_NODE: begin
                // stop at the first entry with more time left
                if (CMP_W'(rem) > CMP_W'(r_delay)) begin
                    n_state = S_LINK_A;
                end else begin
                    n_before = r_q;
                    n_q      = r_rd_next;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_INS_WALK;
                end
            end
            S_LINK_A: begin
                exp_we  = 1'b1; exp_wa  = IDX_W'(r_task); exp_wd  = r_exp;
                bkt_we  = 1'b1; bkt_wa  = IDX_W'(r_task); bkt_wd  = r_bkt;
                prev_we = 1'b1; prev_wa = IDX_W'(r_task); prev_wd = r_before;
                next_we = 1'b1; next_wa = IDX_W'(r_task);
                next_wd = (r_q >= NIL) ? NIL : r_q;
                inw_set = 1'b1; inw_idx = IDX_W'(r_task);
                if (r_before >= NIL) begin
                    head_we = 1'b1;
                    head_wa = r_bkt;
                    head_wd = LINK_W'(r_task);
                end
                n_state = S_LINK_B;
            end
            S_LINK_B: begin
                if (r_before < NIL) begin
                    next_we = 1'b1;
                    next_wa = r_before[IDX_W-1:0];
                    next_wd = LINK_W'(r_task);
                end
                if (r_q < NIL) begin
                    prev_we = 1'b1;
                    prev_wa = r_q[IDX_W-1:0];
                    prev_wd = LINK_W'(r_task);
                end
                n_state = S_FINISH;
            end
            S_UNLINK: begin
                unl     = 1'b1;
                inw_idx = IDX_W'(r_task);
                n_state = S_FINISH;
            end
            S_TICK_WALK: begin
                if (r_q >= NIL || r_cnt == CNT_W'(LIMIT)) begin
                    n_state = S_FINISH;
                end else begin
                    rd_addr = r_q[IDX_W-1:0];
                    n_state = S_TICK_NODE;
                end
            end
            S_TICK_NODE: begin
                rd_addr = r_q[IDX_W-1:0];
                if (r_rd_exp != r_tick) begin
                    n_state = S_FINISH;
                end else if (!r_pend_vld || out_free) begin
                    // previous due task goes out now that another follows
                    push       = r_pend_vld;
                    n_pend_vld = 1'b1;
                    n_pend     = expire_result(r_rd_kind, TASK_W'(r_q));
                    if (r_rd_kind <= KIND_SLEEP_SUSP) begin
                        unl     = 1'b1;
                        inw_idx = r_q[IDX_W-1:0];
                    end
                    n_q     = r_rd_next;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_TICK_WALK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_res   = r_pend_vld ? r_pend : '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // unlink from the data read at the task's slot
        if (unl) begin
            inw_clr = 1'b1;
            if (r_rd_prev >= NIL) begin
                head_we = 1'b1;
                head_wa = r_rd_bkt;
                head_wd = r_rd_next;
            end else begin
                next_we = 1'b1;
                next_wa = r_rd_prev[IDX_W-1:0];
                next_wd = r_rd_next;
            end
            if (r_rd_next < NIL) begin
                prev_we = 1'b1;
                prev_wa = r_rd_next[IDX_W-1:0];
                prev_wd = r_rd_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            m_exp[exp_wa] <= exp_wd;
        end
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        if (prev_we) begin
            m_prev[prev_wa] <= prev_wd;
        end
        if (kind_we) begin
            m_kind[kind_wa] <= in_kind;
        end
        if (bkt_we) begin
            m_bkt[bkt_wa] <= bkt_wd;
        end
        if (head_we) begin
            m_head[head_wa] <= head_wd;
        end
        r_rd_exp  <= m_exp[rd_addr];
        r_rd_next <= m_next[rd_addr];
        r_rd_prev <= m_prev[rd_addr];
        r_rd_kind <= m_kind[rd_addr];
        r_rd_bkt  <= m_bkt[rd_addr];
        r_rd_head <= r_head_vld[hd_addr] ? m_head[hd_addr] : NIL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= '0;
            r_tick_bkt <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < WHEEL_SIZE; i++) begin
                r_head_vld[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_in_wheel[i] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_tick_bkt <= n_tick_bkt;
            r_pend_vld <= n_pend_vld;
            if (head_we) begin
                r_head_vld[head_wa] <= 1'b1;
            end
            if (inw_set) begin
                r_in_wheel[inw_idx] <= 1'b1;
            end else if (inw_clr) begin
                r_in_wheel[inw_idx] <= 1'b0;
            end
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_exp    <= n_exp;
        r_delay  <= n_delay;
        r_task   <= n_task;
        r_bkt    <= n_bkt;
        r_modc   <= n_modc;
        r_q      <= n_q;
        r_before <= n_before;
        r_cnt    <= n_cnt;
        r_pend   <= n_pend;
        if (push) begin
            r_out      <= push_res;
            r_out_last <= push_last;
            r_out_tick <= r_tick;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'b000, OUT_TICK_W'(r_out_tick), r_out.add_to_ready,
                         r_out.reset_mutex_priority, r_out.leave_block_list,
                         r_out.block_result, r_out.new_state, r_out.task_id,
                         r_out.expired, r_out.status};

    // every transfer in takes the sequencer out of idle
    `HTW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_fire, r_state != S_IDLE)
    // a result never overwrites one that is still waiting
    `HTW_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, push && r_out_vld, i_m_tready)
    // the due-task scan stays within the result cap
    `HTW_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, r_state == S_TICK_WALK, r_cnt <= CNT_W'(LIMIT))

endmodule
